@@ src/pths_pkg.sv @@
`default_nettype none
package pths_pkg;

    localparam int HW = 6;
    localparam int TW = 64;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_CANCEL   = 2'd1;
    localparam logic [1:0] REQ_TICK     = 2'd2;
    localparam logic [1:0] REQ_NONE     = 2'd3;

    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_FIRED      = 3'd2;
    localparam logic [2:0] ST_IDLE       = 3'd3;
    localparam logic [2:0] ST_CANCELLED  = 3'd4;
    localparam logic [2:0] ST_IGNORED    = 3'd5;

    typedef struct packed {
        logic [1:0]    req_type;
        logic [TW-1:0] time_value;
        logic [TW-1:0] period_in;
        logic [HW-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [2:0]    status;
        logic [HW-1:0] handle_out;
        logic [TW-1:0] fire_time;
        logic [TW-1:0] period_out;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INSERT,
        OP_UP_RD,
        OP_UP_CMP,
        OP_TOP_RD,
        OP_PER_RD,
        OP_POP,
        OP_ADVANCE,
        OP_DN_RD,
        OP_DN_RDR,
        OP_DN_CMP,
        OP_DN_SWAP,
        OP_CANCEL,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic       heap_empty;
        logic       top_due;
        logic       top_live;
        logic       top_periodic;
        logic       free_found;
        logic       heap_full;
        logic       cancel_ok;
        logic       up_swap;
        logic       up_done;
        logic       dn_done;
        logic       dn_swap;
        logic [1:0] req_type;
    } sts_t;

endpackage
`default_nettype wire

@@ src/periodic_timer_heap_scheduler.sv @@
// Path from accept to m_valid: cancel, full and unused requests go straight to the result;
// register adds a sift-up compare per level; tick pops dead entries and fires at most one
// due timer, each followed by a sift-down per level, until the heap is empty or the top is not due.
// Throughput: one request in flight; the next is accepted in the cycle after the result
// transfer. A tick may drain a full heap of dead entries before it answers.
// Reset: aresetn synchronous active low clears heap count, slot flags and controller.
`default_nettype none
module periodic_timer_heap_scheduler #(
    parameter int MAX_TIMERS = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pths_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pths_pkg::rsp_t      m_data
);
    import pths_pkg::*;

    localparam int CAP = (MAX_TIMERS < 64) ? MAX_TIMERS : 64;
    localparam int AW  = $clog2(CAP);

    cmd_t cmd;
    sts_t sts;

    pths_datapath #(.CAP(CAP), .AW(AW)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .req(s_data), .cmd(cmd), .sts(sts), .rsp(m_data)
    );

    pths_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

`ifndef ASSERT_OFF
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("ready and valid together");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

@@ src/pths_datapath.sv @@
`default_nettype none
module pths_datapath #(
    parameter int CAP = 64,
    parameter int AW  = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pths_pkg::req_t req,
    input  wire pths_pkg::cmd_t cmd,
    output pths_pkg::sts_t     sts,
    output pths_pkg::rsp_t     rsp
);
    import pths_pkg::*;

    localparam int CW = AW + 1;

    logic [TW-1:0] mem_d [CAP];
    logic [HW-1:0] mem_h [CAP];
    logic [TW-1:0] mem_p [CAP];
    logic [CAP-1:0] used_reg, live_reg;
    logic [CW-1:0] count_reg;

    req_t          req_reg;
    logic [AW-1:0] pos_reg, oth_reg;
    logic [TW-1:0] cd_reg, od_reg, rd_reg;
    logic [HW-1:0] ch_reg, oh_reg, rh_reg;
    logic [TW-1:0] per_reg;
    logic [AW-1:0] mptr_reg;
    logic [CW-1:0] l_idx, r_idx;
    rsp_t          rsp_reg;

    logic [AW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = AW'(i);
                free_any = 1'b1;
            end
        end
    end

    function automatic logic earlier(input logic [TW-1:0] da, input logic [HW-1:0] ha,
                                     input logic [TW-1:0] db, input logic [HW-1:0] hb);
        earlier = (da != db) ? (da < db) : (ha < hb);
    endfunction

    logic [AW-1:0] ch_idx;
    assign ch_idx = ch_reg[AW-1:0];
    assign l_idx = {pos_reg, 1'b1};
    assign r_idx = l_idx + CW'(1);

    logic l_ok, r_ok, r_better;
    assign l_ok = l_idx < count_reg;
    assign r_ok = r_idx < count_reg;
    assign r_better = r_ok && earlier(rd_reg, rh_reg, od_reg, oh_reg);

    always_comb begin
        sts.heap_empty   = count_reg == '0;
        sts.heap_full    = count_reg >= CW'(CAP);
        sts.top_due      = req_reg.time_value >= cd_reg;
        sts.top_live     = live_reg[ch_idx];
        sts.top_periodic = per_reg != '0;
        sts.free_found   = free_any;
        sts.cancel_ok    = (int'(req_reg.handle_in) < CAP) &&
                           used_reg[req_reg.handle_in[AW-1:0]] &&
                           live_reg[req_reg.handle_in[AW-1:0]];
        sts.up_swap      = (pos_reg != '0) && earlier(cd_reg, ch_reg, od_reg, oh_reg);
        sts.up_done      = pos_reg == '0;
        sts.dn_done      = !l_ok;
        sts.dn_swap      = earlier(od_reg, oh_reg, cd_reg, ch_reg);
        sts.req_type     = req_reg.req_type;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            live_reg  <= '0;
            count_reg <= '0;
        end else begin
            unique case (cmd.op)
                OP_LOAD: begin
                    req_reg <= req;
                    rsp_reg <= '0;
                end
                OP_INSERT: begin
                    used_reg[free_idx] <= 1'b1;
                    live_reg[free_idx] <= 1'b1;
                    mem_p[free_idx] <= req_reg.period_in;
                    mem_d[count_reg[AW-1:0]] <= req_reg.time_value;
                    mem_h[count_reg[AW-1:0]] <= HW'(free_idx);
                    pos_reg   <= count_reg[AW-1:0];
                    cd_reg    <= req_reg.time_value;
                    ch_reg    <= HW'(free_idx);
                    count_reg <= count_reg + CW'(1);
                    rsp_reg.handle_out <= HW'(free_idx);
                end
                OP_UP_RD: begin
                    oth_reg <= AW'((pos_reg - AW'(1)) >> 1);
                    od_reg  <= mem_d[AW'((pos_reg - AW'(1)) >> 1)];
                    oh_reg  <= mem_h[AW'((pos_reg - AW'(1)) >> 1)];
                end
                OP_UP_CMP: begin
                    if (sts.up_swap) begin
                        mem_d[pos_reg] <= od_reg;
                        mem_h[pos_reg] <= oh_reg;
                        mem_d[oth_reg] <= cd_reg;
                        mem_h[oth_reg] <= ch_reg;
                        pos_reg <= oth_reg;
                    end
                end
                OP_TOP_RD: begin
                    cd_reg  <= mem_d[0];
                    ch_reg  <= mem_h[0];
                    pos_reg <= '0;
                end
                OP_PER_RD: per_reg <= mem_p[ch_idx];
                OP_POP: begin
                    used_reg[ch_idx] <= 1'b0;
                    live_reg[ch_idx] <= 1'b0;
                    count_reg <= count_reg - CW'(1);
                    mem_d[0] <= mem_d[AW'(count_reg - CW'(1))];
                    mem_h[0] <= mem_h[AW'(count_reg - CW'(1))];
                    cd_reg   <= mem_d[AW'(count_reg - CW'(1))];
                    ch_reg   <= mem_h[AW'(count_reg - CW'(1))];
                    pos_reg  <= '0;
                    if (cmd.status == ST_FIRED) begin
                        rsp_reg.handle_out <= ch_reg;
                        rsp_reg.fire_time  <= req_reg.time_value;
                        rsp_reg.period_out <= per_reg;
                    end
                end
                OP_ADVANCE: begin
                    rsp_reg.handle_out <= ch_reg;
                    rsp_reg.fire_time  <= req_reg.time_value;
                    rsp_reg.period_out <= per_reg;
                    cd_reg   <= cd_reg + per_reg;
                    mem_d[0] <= cd_reg + per_reg;
                    pos_reg  <= '0;
                end
                OP_DN_RD: begin
                    od_reg <= mem_d[l_idx[AW-1:0]];
                    oh_reg <= mem_h[l_idx[AW-1:0]];
                    mptr_reg <= l_idx[AW-1:0];
                end
                OP_DN_RDR: begin
                    rd_reg <= mem_d[r_ok ? r_idx[AW-1:0] : l_idx[AW-1:0]];
                    rh_reg <= mem_h[r_ok ? r_idx[AW-1:0] : l_idx[AW-1:0]];
                end
                OP_DN_CMP: begin
                    if (r_better) begin
                        od_reg <= rd_reg;
                        oh_reg <= rh_reg;
                        mptr_reg <= r_idx[AW-1:0];
                    end
                end
                OP_DN_SWAP: begin
                    mem_d[pos_reg]  <= od_reg;
                    mem_h[pos_reg]  <= oh_reg;
                    mem_d[mptr_reg] <= cd_reg;
                    mem_h[mptr_reg] <= ch_reg;
                    pos_reg <= mptr_reg;
                end
                OP_CANCEL: begin
                    live_reg[req_reg.handle_in[AW-1:0]] <= 1'b0;
                    rsp_reg.handle_out <= req_reg.handle_in;
                end
                OP_RESULT: rsp_reg.status <= cmd.status;
                default: ;
            endcase
        end
    end

    assign rsp = rsp_reg;
endmodule
`default_nettype wire

@@ src/pths_ctrl.sv @@
`default_nettype none
module pths_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire pths_pkg::sts_t sts,
    output pths_pkg::cmd_t     cmd
);
    import pths_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_UPRD = 4'd2, S_UPCMP = 4'd3,
                           S_TOP = 4'd4, S_CHK = 4'd5, S_DNRD = 4'd6, S_DNRDR = 4'd7,
                           S_DNCMP = 4'd8, S_DNSW = 4'd9, S_DONE = 4'd10, S_OUT = 4'd11,
                           S_PRD = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       fin_reg, fin_next;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        fin_next   = fin_reg;
        cmd.op     = OP_NONE;
        cmd.status = ST_IDLE;
        unique case (state_reg)
            S_IDLE: if (s_valid) begin
                cmd.op = OP_LOAD;
                state_next = S_DEC;
            end
            S_DEC: begin
                fin_next = 1'b0;
                priority if (sts.req_type == REQ_REGISTER) begin
                    if (sts.free_found && !sts.heap_full) begin
                        cmd.op = OP_INSERT;
                        st_next = ST_REGISTERED;
                        state_next = S_UPRD;
                    end else begin
                        st_next = ST_FULL;
                        state_next = S_DONE;
                    end
                end else if (sts.req_type == REQ_CANCEL) begin
                    if (sts.cancel_ok) begin
                        cmd.op = OP_CANCEL;
                        st_next = ST_CANCELLED;
                    end else st_next = ST_IGNORED;
                    state_next = S_DONE;
                end else if (sts.req_type == REQ_TICK) begin
                    st_next = ST_IDLE;
                    state_next = S_TOP;
                end else begin
                    st_next = ST_IDLE;
                    state_next = S_DONE;
                end
            end
            S_UPRD: begin
                if (sts.up_done) state_next = S_DONE;
                else begin
                    cmd.op = OP_UP_RD;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                cmd.op = OP_UP_CMP;
                state_next = sts.up_swap ? S_UPRD : S_DONE;
            end
            S_TOP: begin
                if (sts.heap_empty || fin_reg) state_next = S_DONE;
                else begin
                    cmd.op = OP_TOP_RD;
                    state_next = S_PRD;
                end
            end
            S_PRD: begin
                cmd.op = OP_PER_RD;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (!sts.top_due) state_next = S_DONE;
                else if (!sts.top_live) begin
                    cmd.op = OP_POP;
                    state_next = S_DNRD;
                end else begin
                    st_next = ST_FIRED;
                    fin_next = 1'b1;
                    cmd.status = ST_FIRED;
                    cmd.op = sts.top_periodic ? OP_ADVANCE : OP_POP;
                    state_next = S_DNRD;
                end
            end
            S_DNRD: begin
                if (sts.dn_done) state_next = S_TOP;
                else begin
                    cmd.op = OP_DN_RD;
                    state_next = S_DNRDR;
                end
            end
            S_DNRDR: begin
                cmd.op = OP_DN_RDR;
                state_next = S_DNCMP;
            end
            S_DNCMP: begin
                cmd.op = OP_DN_CMP;
                state_next = S_DNSW;
            end
            S_DNSW: begin
                if (sts.dn_swap) begin
                    cmd.op = OP_DN_SWAP;
                    state_next = S_DNRD;
                end else state_next = S_TOP;
            end
            S_DONE: begin
                cmd.op = OP_RESULT;
                cmd.status = st_reg;
                state_next = S_OUT;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            fin_reg   <= fin_next;
        end
    end
endmodule
`default_nettype wire
